/* hdl/jps_pkg.sv */
// Shared constants for the Jacobi Poisson stencil step.
package jps_pkg;

	// Largest supported interior size and line buffer depth
	localparam int MAX_GRID = 1024;
	localparam int DEPTH    = MAX_GRID + 2;
	localparam int ADDR_W   = $clog2(DEPTH);

	// Field widths
	localparam int VAL_W = 32;
	localparam int IDX_W = 11;
	localparam int H2_W  = 32;

	// Stream payload widths, padded to whole bytes
	localparam int IN_W  = 64;
	localparam int OUT_W = 56;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_SIZE = 1'b0,
		CFG_H_SQUARED = 1'b1
	} cfg_reg_t;

	localparam logic [IDX_W-1:0] GRID_SIZE_RST = IDX_W'(1024);
	localparam logic [H2_W-1:0]  H_SQUARED_RST = H2_W'(4087);

endpackage

/* hdl/jacobi_poisson_stencil_step.sv */
// Streaming five-point Jacobi update for the 2D Poisson problem.
// Grid samples (u and f) enter in column-major order, boundary included, one beat per cycle
// while s_tready is high; s_tuser marks sample (0,0). For each interior point (i,j-1) the
// block returns (h^2*f + four neighbors)/4, rounded half up and saturated to Q8.24, together
// with its row and column and a tlast flag on point (N,N). Throughput is one sample per clock
// while m_tready is held high; a result passes the stage 1, stage 2 and output registers after
// the sample at (i,j) is taken. The rate is set by the line buffers: three 1026 x 32 memories,
// one write port each, with the u buffer read at two rows per cycle; the older-column write
// trails by one stage and is bypassed. The buffers come up undefined and have no clearing pass:
// the first two columns after reset must be streamed before any interior point uses them.
module jacobi_poisson_stencil_step (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [jps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [jps_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input samples
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [jps_pkg::IN_W-1:0]        s_tdata,   // u_value[31:0], f_value[63:32]
	input  logic                            s_tuser,   // start_of_grid
	// updated points
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [jps_pkg::OUT_W-1:0]       m_tdata,   // new_value[31:0], row_index[42:32],
	                                                   // column_index[53:43], zero[55:54]
	output logic                            m_tlast    // last_point
);
	import jps_pkg::*;

	// configuration registers
	logic [IDX_W-1:0] grid_size_q;
	logic [H2_W-1:0]  h_squared_q;

	// position counters
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;

	// line buffers
	logic [VAL_W-1:0] prev_u_mem  [DEPTH];
	logic [VAL_W-1:0] older_u_mem [DEPTH];
	logic [VAL_W-1:0] prev_f_mem  [DEPTH];

	// input side
	logic             acc;
	logic [IDX_W-1:0] n_eff;
	logic [IDX_W-1:0] n_plus2;
	logic [IDX_W-1:0] i_in;
	logic [IDX_W-1:0] j_in;
	logic [IDX_W-1:0] i_inc;
	logic [IDX_W-1:0] j_inc;
	logic             emit_in;
	logic             last_in;
	logic [VAL_W-1:0] u_in;
	logic [VAL_W-1:0] f_in;

	// stage 1: buffer read data
	logic             v_s1;
	logic             emit_s1;
	logic             last_s1;
	logic [IDX_W-1:0] i_s1;
	logic [IDX_W-1:0] col_s1;
	logic [VAL_W-1:0] u_s1;
	logic [VAL_W-1:0] rd_prev_s1;
	logic [VAL_W-1:0] rd_down_s1;
	logic [VAL_W-1:0] rd_older_s1;
	logic [VAL_W-1:0] rd_f_s1;
	logic             hit_s1;
	logic [VAL_W-1:0] fwd_s1;
	logic [VAL_W-1:0] up_q;
	logic [VAL_W-1:0] left_s1;
	logic signed [VAL_W+1:0] sum_s1;
	logic signed [VAL_W+H2_W:0] prod_s1;

	// stage 2: product and neighbor sum
	logic             v_s2;
	logic             emit_s2;
	logic             last_s2;
	logic [IDX_W-1:0] row_s2;
	logic [IDX_W-1:0] col_s2;
	logic signed [VAL_W+1:0]    sum_s2;
	logic signed [VAL_W+H2_W:0] prod_s2;
	logic signed [66:0]         total_s2;
	logic signed [32:0]         quot_s2;
	logic [VAL_W-1:0]           sat_s2;

	// output register
	logic             out_valid_q;
	logic [VAL_W-1:0] out_value_q;
	logic [IDX_W-1:0] out_row_q;
	logic [IDX_W-1:0] out_col_q;
	logic             out_last_q;

	// flow control
	logic o_free;
	logic adv2;
	logic s2_free;
	logic adv1;

	localparam logic signed [66:0] ROUND_HALF = 67'sh2_0000_0000;

	// stall chain from the output back to the input
	assign o_free   = !out_valid_q || m_tready;
	assign adv2     = v_s2 && (o_free || !emit_s2);
	assign s2_free  = !v_s2 || adv2;
	assign adv1     = v_s1 && s2_free;
	assign s_tready = !v_s1 || adv1;
	assign acc      = s_tvalid && s_tready;

	assign u_in = s_tdata[VAL_W-1:0];
	assign f_in = s_tdata[2*VAL_W-1:VAL_W];

	// clamp the grid size into the supported range
	always_comb begin
		if (grid_size_q == '0) begin
			n_eff = IDX_W'(1);
		end else if (grid_size_q > IDX_W'(MAX_GRID)) begin
			n_eff = IDX_W'(MAX_GRID);
		end else begin
			n_eff = grid_size_q;
		end
	end

	assign n_plus2 = n_eff + IDX_W'(2);
	assign i_in    = s_tuser ? '0 : row_q;
	assign j_in    = s_tuser ? '0 : col_q;
	assign i_inc   = i_in + IDX_W'(1);
	assign j_inc   = j_in + IDX_W'(1);
	assign emit_in = (i_in >= IDX_W'(1)) && (i_in <= n_eff) &&
	                 (j_in >= IDX_W'(2)) && (j_in <= n_eff + IDX_W'(1));
	assign last_in = (i_in == n_eff) && (j_in == n_eff + IDX_W'(1));

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_RST;
			h_squared_q <= H_SQUARED_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_GRID_SIZE: grid_size_q <= cfg_data[IDX_W-1:0];
				CFG_H_SQUARED: h_squared_q <= cfg_data[H2_W-1:0];
				default:       ;
			endcase
		end
	end

	// advance row and column on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc) begin
			if (i_inc >= n_plus2) begin
				row_q <= '0;
				col_q <= (j_inc >= n_plus2) ? '0 : j_inc;
			end else begin
				row_q <= i_inc;
				col_q <= j_in;
			end
		end
	end

	// line buffers: read before write, registered read data
	always_ff @(posedge clk) begin
		if (acc) begin
			prev_u_mem[i_in[ADDR_W-1:0]] <= u_in;
			prev_f_mem[i_in[ADDR_W-1:0]] <= f_in;
			rd_prev_s1  <= prev_u_mem[i_in[ADDR_W-1:0]];
			rd_down_s1  <= prev_u_mem[i_inc[ADDR_W-1:0]];
			rd_f_s1     <= prev_f_mem[i_in[ADDR_W-1:0]];
			rd_older_s1 <= older_u_mem[i_in[ADDR_W-1:0]];
		end
		if (adv1) begin
			older_u_mem[i_s1[ADDR_W-1:0]] <= rd_prev_s1;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	// stage 1 payload, with bypass of the pending older-column write
	always_ff @(posedge clk) begin
		if (acc) begin
			emit_s1 <= emit_in;
			last_s1 <= last_in;
			i_s1    <= i_in;
			col_s1  <= j_in - IDX_W'(1);
			u_s1    <= u_in;
			hit_s1  <= v_s1 && (i_s1 == i_in);
			fwd_s1  <= rd_prev_s1;
		end
		// hold the upper neighbor: previous column at the row just left
		if (adv1) begin
			up_q <= rd_prev_s1;
		end
	end

	assign left_s1 = hit_s1 ? fwd_s1 : rd_older_s1;

	// sum the four neighbors and form h^2*f
	assign sum_s1 = $signed({{2{up_q[VAL_W-1]}}, up_q}) +
	                $signed({{2{rd_down_s1[VAL_W-1]}}, rd_down_s1}) +
	                $signed({{2{left_s1[VAL_W-1]}}, left_s1}) +
	                $signed({{2{u_s1[VAL_W-1]}}, u_s1});
	assign prod_s1 = $signed({1'b0, h_squared_q}) * $signed(rd_f_s1);

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= adv1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			row_s2  <= i_s1;
			col_s2  <= col_s1;
			sum_s2  <= sum_s1;
			prod_s2 <= prod_s1;
		end
	end

	// scale by a quarter, round half up, saturate to Q8.24
	assign total_s2 = $signed({sum_s2[VAL_W+1], sum_s2, 32'd0}) +
	                  $signed({{2{prod_s2[VAL_W+H2_W]}}, prod_s2}) + ROUND_HALF;
	assign quot_s2  = total_s2[66:34];

	always_comb begin
		if (quot_s2[32] != quot_s2[31]) begin
			sat_s2 = quot_s2[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			sat_s2 = quot_s2[31:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (o_free) begin
			out_valid_q <= v_s2 && emit_s2;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (o_free && v_s2 && emit_s2) begin
			out_value_q <= sat_s2;
			out_row_q   <= row_s2;
			out_col_q   <= col_s2;
			out_last_q  <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_col_q, out_row_q, out_value_q};
	assign m_tlast  = out_last_q;

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the streaming Jacobi Poisson stencil step.
module tb_top;
	import jps_pkg::*;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BEATS = 760;
	localparam int WARM_N       = 24;

	localparam logic signed [71:0] Q824_MAX = 72'sd2147483647;
	localparam logic signed [71:0] Q824_MIN = -72'sd2147483648;

	typedef enum int {FILL_MIX, FILL_MAX, FILL_MIN} fill_t;

	typedef struct {
		logic [VAL_W-1:0] u;
		logic [VAL_W-1:0] f;
		logic             sog;
	} grid_sample_t;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             is_last;
	} point_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	cfg_reg_t              cfg_index = CFG_GRID_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;  // u_value[31:0], f_value[63:32]
	logic                  s_tuser = 1'b0; // start_of_grid
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;  // new_value[31:0], row_index[42:32], column_index[53:43]
	logic                  m_tlast;  // last_point

	jacobi_poisson_stencil_step dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus and expectation stores
	grid_sample_t sample_q[$];
	point_t       expected_q[$];
	grid_sample_t next_beat;
	point_t       want;

	// Shadow of the block: line buffers, position and registers
	logic [VAL_W-1:0] col_u_prev [DEPTH];
	logic [VAL_W-1:0] col_u_older[DEPTH];
	logic [VAL_W-1:0] col_f_prev [DEPTH];
	int               row_pos = 0;
	int               col_pos = 0;
	logic [IDX_W-1:0] grid_n_reg = GRID_SIZE_RST;
	logic [H2_W-1:0]  h2_reg = H_SQUARED_RST;

	// Traffic shaping and bookkeeping
	bit calm = 1'b0;
	int gap_pct = 20;
	int stall_pct = 20;
	int gap_left = 0;
	int stall_left = 0;
	int beats_left = 0;
	int beats_sent = 0;
	int points_checked = 0;
	int phases_run = 0;
	int error_count = 0;
	int cycle_count = 0;

	function automatic logic signed [71:0] widen(input logic [VAL_W-1:0] v);
		return {{40{v[VAL_W-1]}}, v};
	endfunction

	function automatic int eff_grid();
		if (grid_n_reg == 0)
			return 1;
		if (grid_n_reg > MAX_GRID)
			return MAX_GRID;
		return int'(grid_n_reg);
	endfunction

	// (h^2*f + 2^32*sum) / 2^34, round half up, clamp to Q8.24
	function automatic logic [VAL_W-1:0] stencil_q824(input logic [VAL_W-1:0] fc,
			input logic [VAL_W-1:0] up, input logic [VAL_W-1:0] down,
			input logic [VAL_W-1:0] left, input logic [VAL_W-1:0] here);
		logic signed [71:0] nb;
		logic signed [71:0] prod;
		logic signed [71:0] acc;
		nb = widen(up) + widen(down) + widen(left) + widen(here);
		prod = $signed({40'd0, h2_reg}) * widen(fc);
		acc = (nb <<< 32) + prod + (72'sd1 <<< 33);
		acc = acc >>> 34;
		if (acc > Q824_MAX)
			return 32'h7fff_ffff;
		if (acc < Q824_MIN)
			return 32'h8000_0000;
		return acc[VAL_W-1:0];
	endfunction

	// Consume one accepted sample: emit the expected point, shift buffers, advance position
	task automatic advance_grid(input logic [VAL_W-1:0] u, input logic [VAL_W-1:0] f,
			input logic sog);
		int     n;
		int     i;
		int     j;
		point_t pt;
		n = eff_grid();
		i = row_pos;
		j = col_pos;
		if (sog) begin
			i = 0;
			j = 0;
		end
		if (i >= 1 && i <= n && j >= 2 && j <= n + 1) begin
			pt.value = stencil_q824(col_f_prev[i], col_u_older[i-1], col_u_prev[i+1],
				col_u_older[i], u);
			pt.row = IDX_W'(i);
			pt.col = IDX_W'(j - 1);
			pt.is_last = (i == n && j == n + 1);
			expected_q.push_back(pt);
		end
		if (i < DEPTH) begin
			col_u_older[i] = col_u_prev[i];
			col_u_prev[i] = u;
			col_f_prev[i] = f;
		end
		i++;
		if (i >= n + 2) begin
			i = 0;
			j++;
			if (j >= n + 2)
				j = 0;
		end
		row_pos = i;
		col_pos = j;
	endtask

	function automatic logic [VAL_W-1:0] fill_word(input fill_t mode);
		case (mode)
			FILL_MAX: return 32'h7fff_ffff;
			FILL_MIN: return 32'h8000_0000;
			default: begin
				case ($urandom_range(0, 7))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'($urandom_range(0, 32'h01ff_ffff)) - 32'h0100_0000;
					default: return $urandom();
				endcase
			end
		endcase
	endfunction

	function automatic logic [H2_W-1:0] pick_h2();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return H2_W'($urandom_range(0, 65535));
			default: return $urandom();
		endcase
	endfunction

	// Queue a run of samples; stray markers restart the sweep mid-grid
	task automatic push_samples(input int count, input bit first_marker,
			input int stray_permille, input fill_t mode);
		grid_sample_t smp;
		for (int k = 0; k < count; k++) begin
			smp.u = fill_word(mode);
			smp.f = fill_word(mode);
			smp.sog = (k == 0) ? first_marker : ($urandom_range(0, 999) < stray_permille);
			sample_q.push_back(smp);
		end
		beats_left += count;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_GRID_SIZE: grid_n_reg = data[IDX_W-1:0];
			CFG_H_SQUARED: h2_reg = data;
			default: ;
		endcase
	endtask

	// Wait until every beat is taken and every point has come out, then let the pipe empty
	task automatic drain();
		while (beats_left != 0 || expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		phases_run++;
	endtask

	// Driver: present queued samples, with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_grid(s_tdata[31:0], s_tdata[63:32], s_tuser);
				beats_left--;
				beats_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
					gap_left = $urandom_range(0, 15);
					s_tvalid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					next_beat = sample_q.pop_front();
					s_tdata <= {next_beat.f, next_beat.u};
					s_tuser <= next_beat.sog;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat against the oldest expected point, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no point pending: value %h row %0d col %0d",
						m_tdata[31:0], m_tdata[42:32], m_tdata[53:43]);
					error_count++;
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[31:0] !== want.value) begin
						$error("new_value: expected %h, got %h", want.value, m_tdata[31:0]);
						error_count++;
					end
					if (m_tdata[42:32] !== want.row) begin
						$error("row_index: expected %0d, got %0d", want.row, m_tdata[42:32]);
						error_count++;
					end
					if (m_tdata[53:43] !== want.col) begin
						$error("column_index: expected %0d, got %0d", want.col, m_tdata[53:43]);
						error_count++;
					end
					if (m_tlast !== want.is_last) begin
						$error("last_point: expected %0d, got %0d", want.is_last, m_tlast);
						error_count++;
					end
					if (m_tdata[55:54] !== 2'b00) begin
						$error("tdata pad: expected 0, got %0d", m_tdata[55:54]);
						error_count++;
					end
					points_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** jacobi_poisson_stencil_step: FAILED **");
			$finish;
		end
	end

	initial begin
		int                    n;
		int                    prev_n;
		int                    len;
		int                    sweeps;
		int                    random_beats;
		bit                    marker;
		logic [CFG_DATA_W-1:0] data;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Smallest grid at reset h^2: all samples at full scale, saturates high
		write_reg(CFG_GRID_SIZE, 1);
		push_samples(9, 1'b1, 0, FILL_MAX);
		drain();

		// Size zero acts as one; full h^2 on negative full scale saturates low.
		// No marker: the position wrapped back to the origin on its own.
		write_reg(CFG_H_SQUARED, '1);
		write_reg(CFG_GRID_SIZE, 0);
		push_samples(9, 1'b0, 0, FILL_MIN);
		drain();

		// Fill the low rows of every line buffer: two full columns and the top of the third
		gap_pct = 5;
		stall_pct = 5;
		write_reg(CFG_GRID_SIZE, WARM_N);
		write_reg(CFG_H_SQUARED, pick_h2());
		push_samples(2 * (WARM_N + 2) + 1, 1'b1, 0, FILL_MIX);
		drain();

		// Oversized setting clamps to the largest grid; carry on down the third column
		// while every neighbor row is already filled
		write_reg(CFG_GRID_SIZE, 32'h0000_07ff);
		push_samples(WARM_N, 1'b0, 0, FILL_MIX);
		drain();
		prev_n = MAX_GRID;

		// Random phases: mostly whole sweeps on small grids, some cut short or restarted
		random_beats = 0;
		while (random_beats < RANDOM_BEATS) begin
			case ($urandom_range(0, 15))
				0: data = 0;
				1: data = $urandom_range(9, WARM_N);
				default: data = $urandom_range(1, 8);
			endcase
			if ($urandom_range(0, 1))
				data = data | ($urandom() & 32'hffff_f800);
			write_reg(CFG_GRID_SIZE, data);
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_H_SQUARED, pick_h2());
			n = eff_grid();
			// A larger grid needs a fresh origin; a smaller one may pick up mid-sweep
			marker = (n > prev_n) || $urandom_range(0, 1);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 8;
				default: gap_pct = 30;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 8;
				default: stall_pct = 30;
			endcase
			sweeps = $urandom_range(1, 3);
			for (int s = 0; s < sweeps && random_beats < RANDOM_BEATS; s++) begin
				len = (n + 2) * (n + 2);
				if ($urandom_range(0, 5) == 0)
					len = $urandom_range(1, len);
				if (len > RANDOM_BEATS - random_beats)
					len = RANDOM_BEATS - random_beats;
				push_samples(len, (s == 0) ? marker : ($urandom_range(0, 3) == 0), 5, FILL_MIX);
				random_beats += len;
			end
			drain();
			prev_n = n;
		end

		// Closing phase at full rate on both sides
		calm = 1'b1;
		write_reg(CFG_GRID_SIZE, $urandom_range(2, 6));
		write_reg(CFG_H_SQUARED, pick_h2());
		n = eff_grid();
		push_samples(2 * (n + 2) * (n + 2), 1'b1, 0, FILL_MIX);
		drain();

		if (expected_q.size() != 0) begin
			$error("%0d expected points never arrived", expected_q.size());
			error_count++;
		end

		$display("Covered %0d sample beats over %0d phases, grid sizes 0 to 2047 written.",
			beats_sent, phases_run);
		$display("Checked %0d updated points, %0d mismatches.", points_checked, error_count);
		if (error_count == 0)
			$display("** jacobi_poisson_stencil_step: PASSED **");
		else
			$display("** jacobi_poisson_stencil_step: FAILED **");
		$finish;
	end

endmodule
